[rtl/iol_pkg.sv]
// Shared constants and codes for the indexed ordered list unit.
`default_nettype none
package iol_pkg;
	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ACT_W    = 3;
	localparam int POS_W    = 6;
	localparam int VAL_W    = 32;
	localparam int STAT_W   = 2;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_PRINT  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_MIN    = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_INDEX = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;
endpackage
`default_nettype wire

[rtl/iol_req_if.sv]
// Request channel: action, position and value with valid/ready.
`default_nettype none
interface iol_req_if;
	logic                          valid;
	logic                          ready;
	logic [iol_pkg::ACT_W-1:0]     action;
	logic [iol_pkg::POS_W-1:0]     position;
	logic signed [iol_pkg::VAL_W-1:0] value_in;

	modport source (output valid, action, position, value_in, input ready);
	modport sink   (input valid, action, position, value_in, output ready);
endinterface
`default_nettype wire

[rtl/iol_rsp_if.sv]
// Result channel: value, status and last flag with valid/ready.
`default_nettype none
interface iol_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [iol_pkg::VAL_W-1:0] value_out;
	logic [iol_pkg::STAT_W-1:0]       status;
	logic                             last;

	modport source (output valid, value_out, status, last, input ready);
	modport sink   (input valid, value_out, status, last, output ready);
endinterface
`default_nettype wire

[rtl/iol_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module iol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/iol_min.sv]
// Running signed minimum: one compare-and-select per cycle while en is high.
`default_nettype none
module iol_min (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic                             first,
	input  wire logic [iol_pkg::VAL_W-1:0]        data,
	output logic signed [iol_pkg::VAL_W-1:0]      best_q
);
	import iol_pkg::*;

	logic take;

	assign take = first || ($signed(data) < best_q);

	always_ff @(posedge clk) begin
		if (en && take) begin
			best_q <= $signed(data);
		end
	end
endmodule
`default_nettype wire

[rtl/indexed_ordered_list_unit.sv]
// Top level: request sequencer, element RAM, minimum unit, result register.
//
//  channel | dir | payload                     | handshake
//  --------+-----+-----------------------------+-------------------
//  req     | in  | action, position, value_in  | valid/ready
//  rsp     | out | value_out, status, last     | valid/ready
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Insert and delete shifts and the minimum scan walk one entry per cycle through
// the single read port of the element RAM; print reads each entry in S_PR_RD and
// hands it over in S_PR_EM.
// Reset clears the count and control; RAM contents are undefined until written.
// A stalled rsp holds the sequencer only where it has a result to hand over.
`default_nettype none
module indexed_ordered_list_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	iol_req_if.sink    req,
	iol_rsp_if.source  rsp
);
	import iol_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP,
		S_PUT,
		S_DN_HEAD,
		S_DN,
		S_PR_RD,
		S_PR_EM,
		S_MIN,
		S_MIN_END,
		S_RESULT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [IDX_W-1:0]   pos_q;
	logic [VAL_W-1:0]   val_q;
	logic [VAL_W-1:0]   res_value_q;
	logic [STAT_W-1:0]  res_status_q;
	logic               pend_q;
	logic [IDX_W-1:0]   wa_q;
	logic               mv_q;
	logic               fst_q;

	logic               out_valid_q;
	logic [VAL_W-1:0]   out_value_q;
	logic [STAT_W-1:0]  out_status_q;
	logic               out_last_q;

	logic               accept;
	logic               slot_free;
	logic               emit;
	logic [CMP_W-1:0]   pos_ext;
	logic [CMP_W-1:0]   cnt_ext;
	logic [CMP_W-1:0]   ins_ext;
	logic [CNT_W-1:0]   ptr_m1;
	logic [CNT_W-1:0]   ptr_p1;
	logic               del_ok;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [VAL_W-1:0]   ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [VAL_W-1:0]   ram_rdata;
	logic signed [VAL_W-1:0] best;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || rsp.ready;
	assign emit      = slot_free && ((state_q == S_PR_EM) || (state_q == S_RESULT));
	assign pos_ext   = CMP_W'(req.position);
	assign cnt_ext   = CMP_W'(cnt_q);
	assign ins_ext   = (req.action == ACT_APPEND) ? cnt_ext : pos_ext;
	assign ptr_m1    = ptr_q - CNT_W'(1);
	assign ptr_p1    = ptr_q + CNT_W'(1);
	assign del_ok    = (cnt_q != '0) && (pos_ext < cnt_ext);

	// Write port: pipelined shift writes, or the new value at the insert slot.
	assign ram_we    = pend_q || (state_q == S_PUT);
	assign ram_waddr = (state_q == S_PUT) ? pos_q : wa_q;
	assign ram_wdata = (state_q == S_PUT) ? val_q : ram_rdata;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = ptr_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				ram_re    = accept && (req.action == ACT_DELETE) && del_ok;
				ram_raddr = req.position[IDX_W-1:0];
			end
			S_UP: begin
				ram_re    = (ptr_q > CNT_W'(pos_q));
				ram_raddr = ptr_m1[IDX_W-1:0];
			end
			S_DN:    ram_re = (ptr_q < cnt_q);
			S_PR_RD: ram_re = 1'b1;
			S_MIN:   ram_re = (ptr_q < cnt_q);
			default: ram_re = 1'b0;
		endcase
	end

	iol_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	iol_min u_min (
		.clk    (clk),
		.en     (mv_q),
		.first  (fst_q),
		.data   (ram_rdata),
		.best_q (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			mv_q        <= 1'b0;
			fst_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a shift read this cycle is written back next cycle
			pend_q <= ram_re && ((state_q == S_UP) || (state_q == S_DN));
			mv_q   <= ram_re && (state_q == S_MIN);
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_value_q <= '0;
						case (req.action)
							ACT_APPEND, ACT_INSERT: begin
								if (ins_ext > cnt_ext) begin
									res_status_q <= ST_INDEX;
									state_q      <= S_RESULT;
								end else if (cnt_q >= CNT_W'(CAPACITY)) begin
									res_status_q <= ST_FULL;
									state_q      <= S_RESULT;
								end else begin
									pos_q   <= ins_ext[IDX_W-1:0];
									val_q   <= req.value_in;
									ptr_q   <= cnt_q;
									state_q <= S_UP;
								end
							end
							ACT_DELETE: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_RESULT;
								end else if (!del_ok) begin
									res_status_q <= ST_INDEX;
									state_q      <= S_RESULT;
								end else begin
									pos_q   <= req.position[IDX_W-1:0];
									state_q <= S_DN_HEAD;
								end
							end
							ACT_PRINT, ACT_MIN: begin
								ptr_q <= '0;
								fst_q <= 1'b1;
								if (cnt_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_RESULT;
								end else if (req.action == ACT_PRINT) begin
									state_q <= S_PR_RD;
								end else begin
									state_q <= S_MIN;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_UP: begin
					// Move entries up one slot, tail first.
					if (ptr_q > CNT_W'(pos_q)) begin
						wa_q   <= ptr_q[IDX_W-1:0];
						ptr_q  <= ptr_m1;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					cnt_q        <= cnt_q + CNT_W'(1);
					res_status_q <= ST_OK;
					state_q      <= S_RESULT;
				end
				S_DN_HEAD: begin
					res_value_q <= ram_rdata;
					ptr_q       <= CNT_W'(pos_q) + CNT_W'(1);
					state_q     <= S_DN;
				end
				S_DN: begin
					// Move entries down one slot, head first.
					if (ptr_q < cnt_q) begin
						wa_q   <= ptr_m1[IDX_W-1:0];
						ptr_q  <= ptr_p1;
					end else begin
						cnt_q        <= cnt_q - CNT_W'(1);
						res_status_q <= ST_OK;
						state_q      <= S_RESULT;
					end
				end
				S_PR_RD: state_q <= S_PR_EM;
				S_PR_EM: begin
					if (slot_free) begin
						out_value_q  <= ram_rdata;
						out_status_q <= ST_OK;
						out_last_q   <= (ptr_p1 == cnt_q);
						ptr_q        <= ptr_p1;
						state_q      <= (ptr_p1 == cnt_q) ? S_IDLE : S_PR_RD;
					end
				end
				S_MIN: begin
					if (mv_q) begin
						fst_q <= 1'b0;
					end
					if (ptr_q < cnt_q) begin
						ptr_q <= ptr_p1;
					end else begin
						state_q <= S_MIN_END;
					end
				end
				S_MIN_END: begin
					res_value_q  <= best;
					res_status_q <= ST_OK;
					state_q      <= S_RESULT;
				end
				S_RESULT: begin
					if (slot_free) begin
						out_value_q  <= res_value_q;
						out_status_q <= res_status_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.value_out = out_value_q;
	assign rsp.status    = out_status_q;
	assign rsp.last      = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_q)
		else $error("shift write pending while idle");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
			((cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == $past(cnt_q) - CNT_W'(1))))
		else $error("element count moved by more than one");
endmodule
`default_nettype wire

[tb/iol_order_checker.sv]
// Watches both channels of the list unit, predicts each result and compares it.
module iol_order_checker import iol_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  logic                     req_ready,
	input  logic [ACT_W-1:0]         req_action,
	input  logic [POS_W-1:0]         req_position,
	input  logic signed [VAL_W-1:0]  req_value,
	input  logic                     rsp_valid,
	input  logic                     rsp_ready,
	input  logic signed [VAL_W-1:0]  rsp_value,
	input  logic [STAT_W-1:0]        rsp_status,
	input  logic                     rsp_last,
	output int                       pending,
	output int                       entry_count,
	output int                       mismatches,
	output int                       results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [STAT_W-1:0]       status;
		logic                    last;
	} list_result_t;

	list_result_t            expected_results[$];
	logic signed [VAL_W-1:0] entry_mem[CAPACITY];
	int                      entries;
	int                      bad_tally;
	int                      checked_tally;

	function automatic void queue_result(input logic signed [VAL_W-1:0] v,
			input logic [STAT_W-1:0] st, input logic lst);
		list_result_t r;
		r.value  = v;
		r.status = st;
		r.last   = lst;
		expected_results.push_back(r);
	endfunction

	// Applies one accepted request to the shadow list and queues its results.
	function automatic void apply_request(input logic [ACT_W-1:0] act,
			input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
		int                      where;
		logic signed [VAL_W-1:0] best;
		where = (act == ACT_APPEND) ? entries : int'(pos);
		case (act)
			ACT_APPEND, ACT_INSERT: begin
				// position is checked before capacity
				if (where > entries)
					queue_result('0, ST_INDEX, 1'b1);
				else if (entries >= CAPACITY)
					queue_result('0, ST_FULL, 1'b1);
				else begin
					for (int i = entries; i > where; i--)
						entry_mem[i] = entry_mem[i-1];
					entry_mem[where] = val;
					entries++;
					queue_result('0, ST_OK, 1'b1);
				end
			end
			ACT_DELETE: begin
				if (entries == 0)
					queue_result('0, ST_EMPTY, 1'b1);
				else if (where >= entries)
					queue_result('0, ST_INDEX, 1'b1);
				else begin
					queue_result(entry_mem[where], ST_OK, 1'b1);
					for (int i = where; i + 1 < entries; i++)
						entry_mem[i] = entry_mem[i+1];
					entries--;
				end
			end
			ACT_PRINT: begin
				if (entries == 0)
					queue_result('0, ST_EMPTY, 1'b1);
				else
					for (int i = 0; i < entries; i++)
						queue_result(entry_mem[i], ST_OK, i + 1 == entries);
			end
			ACT_MIN: begin
				if (entries == 0)
					queue_result('0, ST_EMPTY, 1'b1);
				else begin
					best = entry_mem[0];
					for (int i = 1; i < entries; i++)
						if (entry_mem[i] < best)
							best = entry_mem[i];
					queue_result(best, ST_OK, 1'b1);
				end
			end
			default: ; // unused codes: no result, no change
		endcase
	endfunction

	task automatic flag_bad(input string msg);
		bad_tally++;
		if (bad_tally <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			entries         = 0;
			bad_tally       = 0;
			checked_tally   = 0;
			pending         <= 0;
			entry_count     <= 0;
			mismatches      <= 0;
			results_checked <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				checked_tally++;
				if (expected_results.size() == 0)
					flag_bad($sformatf("unexpected result value %0d status %0d last %0b",
						rsp_value, rsp_status, rsp_last));
				else begin
					want = expected_results.pop_front();
					if (rsp_value !== want.value || rsp_status !== want.status ||
							rsp_last !== want.last)
						flag_bad($sformatf(
							"expected value %0d status %0d last %0b, got %0d %0d %0b",
							want.value, want.status, want.last,
							rsp_value, rsp_status, rsp_last));
				end
			end
			if (req_valid && req_ready)
				apply_request(req_action, req_position, req_value);
			pending         <= expected_results.size();
			entry_count     <= entries;
			mismatches      <= bad_tally;
			results_checked <= checked_tally;
		end
	end
endmodule

[tb/tb_top.sv]
// Stimulus, handshake pacing and verdict for the indexed ordered list unit.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import iol_pkg::*;

	localparam int QUIET_LIMIT    = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int ITEMS_PER_MIX  = 43;
	localparam int ACT_TOP        = (1 << ACT_W) - 1;
	localparam logic [POS_W-1:0] POS_TOP = '1;

	logic clk;
	logic arst_n;

	iol_req_if req_ch();
	iol_rsp_if rsp_ch();

	int pending;
	int entry_count;
	int mismatches;
	int results_checked;

	int send_idle_pct;
	int stall_pct;
	int hold_asked;
	int hold_served;
	int hold_left;
	int items_sent;
	int full_visits;

	indexed_ordered_list_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	iol_order_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_ch.valid),
		.req_ready       (req_ch.ready),
		.req_action      (req_ch.action),
		.req_position    (req_ch.position),
		.req_value       (req_ch.value_in),
		.rsp_valid       (rsp_ch.valid),
		.rsp_ready       (rsp_ch.ready),
		.rsp_value       (rsp_ch.value_out),
		.rsp_status      (rsp_ch.status),
		.rsp_last        (rsp_ch.last),
		.pending         (pending),
		.entry_count     (entry_count),
		.mismatches      (mismatches),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: random stalls, plus a long hold-off whenever one is asked for.
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else if (hold_left != 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			rsp_ch.ready <= 1'b0;
			hold_served <= hold_asked;
			hold_left <= LONG_HOLD;
		end else
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Ends the run when no item moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
		$display("indexed_ordered_list_unit regression: fail");
		$finish;
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2, 3:    return VAL_W'($signed($urandom_range(40)) - 20);
			default: return VAL_W'($urandom);
		endcase
	endfunction

	task automatic offer_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid    <= 1'b1;
		req_ch.action   <= act;
		req_ch.position <= pos;
		req_ch.value_in <= val;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// Sender stops until every queued result has come back.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		logic [ACT_W-1:0]        act;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
		int                      made;
		int                      roll;
		bit                      growing;

		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.action   = ACT_APPEND;
		req_ch.position = '0;
		req_ch.value_in = '0;
		rsp_ch.ready    = 1'b0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		hold_asked      = 0;
		hold_served     = 0;
		hold_left       = 0;
		items_sent      = 0;
		full_visits     = 0;
		growing         = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-list errors and bad insert positions
		offer_item(ACT_DELETE, 0, 0);
		offer_item(ACT_PRINT, 0, 0);
		offer_item(ACT_MIN, 0, 0);
		offer_item(ACT_INSERT, 1, 7);
		offer_item(ACT_INSERT, POS_TOP, 7);
		// extremes, head, tail and middle inserts
		offer_item(ACT_APPEND, POS_TOP, 32'sh7FFF_FFFF);
		offer_item(ACT_APPEND, 0, 32'sh8000_0000);
		offer_item(ACT_INSERT, 0, -1);
		offer_item(ACT_INSERT, 3, 0);
		offer_item(ACT_INSERT, 2, 5);
		offer_item(ACT_PRINT, 0, 0);
		offer_item(ACT_MIN, 0, 0);
		for (int c = ACT_MIN + 1; c <= ACT_TOP; c++)
			offer_item(ACT_W'(c), POS_W'($urandom), pick_value());
		// delete at count, far out of range, tail, head, middle
		offer_item(ACT_DELETE, 5, 0);
		offer_item(ACT_DELETE, POS_TOP, 0);
		offer_item(ACT_DELETE, 4, 0);
		offer_item(ACT_DELETE, 0, 0);
		offer_item(ACT_DELETE, 1, 0);
		offer_item(ACT_MIN, 0, 0);
		offer_item(ACT_PRINT, 0, 0);
		drain_results();

		for (int mix = 0; mix < 4; mix++) begin
			case (mix)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
					hold_asked++;
				end
				1: begin
					send_idle_pct = 79;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 79;
				end
				default: begin
					send_idle_pct = 29;
					stall_pct     = 29;
				end
			endcase
			made = 0;
			while (made < ITEMS_PER_MIX) begin
				if (growing && entry_count >= CAPACITY) begin
					// full list: append, valid insert, then an insert past the end
					offer_item(ACT_APPEND, POS_W'($urandom), pick_value());
					offer_item(ACT_INSERT, POS_W'($urandom_range(CAPACITY)), pick_value());
					offer_item(ACT_INSERT, POS_W'($urandom_range(CAPACITY + 1, POS_TOP)),
						pick_value());
					made += 3;
					full_visits++;
					growing = 1'b0;
				end else begin
					if (!growing && entry_count == 0)
						growing = 1'b1;
					roll = $urandom_range(99);
					if (growing)
						act = (roll < 40) ? ACT_APPEND : (roll < 75) ? ACT_INSERT :
							(roll < 85) ? ACT_DELETE : (roll < 91) ? ACT_PRINT :
							(roll < 97) ? ACT_MIN : ACT_W'($urandom_range(ACT_MIN + 1, ACT_TOP));
					else
						act = (roll < 55) ? ACT_DELETE : (roll < 63) ? ACT_APPEND :
							(roll < 70) ? ACT_INSERT : (roll < 80) ? ACT_PRINT :
							(roll < 92) ? ACT_MIN : ACT_W'($urandom_range(ACT_MIN + 1, ACT_TOP));
					if (act == ACT_INSERT)
						pos = ($urandom_range(99) < 85) ? POS_W'($urandom_range(entry_count)) :
							POS_W'($urandom_range(entry_count + 1, POS_TOP));
					else if (act == ACT_DELETE)
						pos = (entry_count > 0 && $urandom_range(99) < 88) ?
							POS_W'($urandom_range(entry_count - 1)) :
							POS_W'($urandom_range(entry_count, POS_TOP));
					else
						pos = POS_W'($urandom);
					val = pick_value();
					offer_item(act, pos, val);
					if (act <= ACT_MIN)
						made++;
				end
			end
			drain_results();
		end

		repeat (100) @(posedge clk);
		$display("covered %0d requests over four pacing mixes with a long result hold-off;",
			items_sent);
		$display("%0d results checked, list driven to capacity %0d times", results_checked,
			full_visits);
		if (mismatches == 0 && pending == 0)
			$display("indexed_ordered_list_unit regression: pass");
		else
			$display("indexed_ordered_list_unit regression: fail");
		$finish;
	end
endmodule

[filelist.f]
rtl/iol_pkg.sv
rtl/iol_req_if.sv
rtl/iol_rsp_if.sv
rtl/iol_ram.sv
rtl/iol_min.sv
rtl/indexed_ordered_list_unit.sv
tb/iol_order_checker.sv
tb/tb_top.sv
